@@ rtl/core/rbm_pkg.sv @@
// ============================================================================
// rbm_pkg
// Shared types and constants for the RGB blend-mode core.
// ============================================================================
`default_nettype none

package rbm_pkg;

  // Channel and configuration widths.
  localparam int PIX_W      = 8;
  localparam int MODE_W     = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int PROD_W     = 2 * PIX_W;

  // Full-scale channel value and the rounding offset for division by 255.
  localparam logic [PIX_W-1:0] PIX_MAX   = 8'd255;
  localparam logic [PIX_W-1:0] ROUND_OFS = 8'd127;

  // Register index of the blend mode register.
  localparam logic REG_BLEND_MODE = 1'b0;

  // Blend operations. Codes 5 to 7 are unused and give a black pixel.
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD      = 3'd0,
    MODE_SUBTRACT = 3'd1,
    MODE_MULTIPLY = 3'd2,
    MODE_SCREEN   = 3'd3,
    MODE_OVERLAY  = 3'd4
  } blend_mode_t;

  // Load strobes for the three pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage : rbm_pkg

`default_nettype wire

@@ rtl/core/rbm_if.sv @@
// ============================================================================
// rbm_if
// Valid/ready channels for input pixel pairs and blended result pixels.
// ============================================================================
`default_nettype none

// Input channel: one top pixel, one bottom pixel and the last-pixel flag.
interface rbm_in_if
  import rbm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] top_red;
  logic [PIX_W-1:0] top_green;
  logic [PIX_W-1:0] top_blue;
  logic [PIX_W-1:0] bottom_red;
  logic [PIX_W-1:0] bottom_green;
  logic [PIX_W-1:0] bottom_blue;
  logic             last_pixel;

  modport source (
    output valid, top_red, top_green, top_blue,
           bottom_red, bottom_green, bottom_blue, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, top_red, top_green, top_blue,
           bottom_red, bottom_green, bottom_blue, last_pixel,
    output ready
  );
endinterface : rbm_in_if

// Result channel: one blended pixel and the copied last-pixel flag.
interface rbm_out_if
  import rbm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             out_last;

  modport source (
    output valid, out_red, out_green, out_blue, out_last,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_last,
    output ready
  );
endinterface : rbm_out_if

`default_nettype wire

@@ rtl/core/rbm_channel.sv @@
// ============================================================================
// rbm_channel
// Three-stage datapath that blends one color channel of a pixel pair.
// ============================================================================
`default_nettype none

module rbm_channel
  import rbm_pkg::*;
(
  input  wire logic              clk,
  input  wire stage_en_t         stage_en,
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [PIX_W-1:0]  top_pix,
  input  wire logic [PIX_W-1:0]  bot_pix,
  output logic [PIX_W-1:0]       result
);

  // Stage 1 registers: operands and flags for the product path.
  logic [PIX_W-1:0] x_r, x_nxt;
  logic [PIX_W-1:0] y_r, y_nxt;
  logic             dbl_r, dbl_nxt;
  logic             inv1_r, inv1_nxt;
  logic             mul1_r, mul1_nxt;
  logic [PIX_W-1:0] direct1_r, direct1_nxt;

  // Stage 2 registers: the (possibly doubled) product.
  logic [PROD_W-1:0] q_r, q_nxt;
  logic              inv2_r;
  logic              mul2_r;
  logic [PIX_W-1:0]  direct2_r;

  // Stage 3 register: the finished channel value.
  logic [PIX_W-1:0] result_r, result_nxt;

  logic [PIX_W:0]    sum;
  logic [PIX_W-1:0]  add_val;
  logic [PIX_W-1:0]  sub_val;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   t_val;
  logic [PROD_W:0]   quo_sum;
  logic [PIX_W-1:0]  rounded;

  // Stage 1: clamped add and subtract, and operand selection for the rest.
  always_comb begin
    sum         = {1'b0, top_pix} + {1'b0, bot_pix};
    add_val     = sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
    sub_val     = (top_pix > bot_pix) ? (top_pix - bot_pix) : '0;
    x_nxt       = top_pix;
    y_nxt       = bot_pix;
    dbl_nxt     = 1'b0;
    inv1_nxt    = 1'b0;
    mul1_nxt    = 1'b0;
    direct1_nxt = '0;
    unique case (mode)
      MODE_ADD: begin
        direct1_nxt = add_val;
      end
      MODE_SUBTRACT: begin
        direct1_nxt = sub_val;
      end
      MODE_MULTIPLY: begin
        mul1_nxt = 1'b1;
      end
      MODE_SCREEN: begin
        // 255 - v is the bitwise complement for an 8-bit value.
        x_nxt    = ~top_pix;
        y_nxt    = ~bot_pix;
        inv1_nxt = 1'b1;
        mul1_nxt = 1'b1;
      end
      MODE_OVERLAY: begin
        mul1_nxt = 1'b1;
        dbl_nxt  = 1'b1;
        // A bottom value of 128 or more takes the screen-like branch.
        if (bot_pix[PIX_W-1]) begin
          x_nxt    = ~top_pix;
          y_nxt    = ~bot_pix;
          inv1_nxt = 1'b1;
        end
      end
      default: begin
        direct1_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (stage_en.s1) begin
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      dbl_r     <= dbl_nxt;
      inv1_r    <= inv1_nxt;
      mul1_r    <= mul1_nxt;
      direct1_r <= direct1_nxt;
    end
  end

  // Stage 2: 8x8 product. Doubling only happens with one operand below 128,
  // so the doubled product still fits in 16 bits.
  always_comb begin
    prod  = x_r * y_r;
    q_nxt = dbl_r ? {prod[PROD_W-2:0], 1'b0} : prod;
  end

  always_ff @(posedge clk) begin
    if (stage_en.s2) begin
      q_r       <= q_nxt;
      inv2_r    <= inv1_r;
      mul2_r    <= mul1_r;
      direct2_r <= direct1_r;
    end
  end

  // Stage 3: round(q / 255) = floor((q + 127) / 255), with the division done
  // as (t + (t >> 8) + 1) >> 8, exact for t below 65535.
  always_comb begin
    t_val   = {1'b0, q_r} + {{(PROD_W+1-PIX_W){1'b0}}, ROUND_OFS};
    quo_sum = t_val + {{PIX_W{1'b0}}, t_val[PROD_W:PIX_W]} + {{PROD_W{1'b0}}, 1'b1};
    rounded = quo_sum[PROD_W-1:PIX_W];
    if (mul2_r) begin
      result_nxt = inv2_r ? (PIX_MAX - rounded) : rounded;
    end else begin
      result_nxt = direct2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en.s3) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule : rbm_channel

`default_nettype wire

@@ rtl/core/rgb_blend_modes_core.sv @@
// ============================================================================
// rgb_blend_modes_core
// Blends a top and a bottom RGB pixel per item with a selectable mode.
// ============================================================================
// Usage:
//   in_ch carries one item per pixel pair: top and bottom red, green, blue
//   and a last-pixel flag. out_ch returns one blended pixel per item, in
//   order, with the flag copied to out_last.
//   The cfg_ port is an APB-style slave with one register at byte address 0:
//   blend_mode (0 add, 1 subtract, 2 multiply, 3 screen, 4 overlay; other
//   codes give black). Change it only while no items are in flight.
//   The three pipeline stages (operand select, 8x8 multiply, round and
//   divide by 255) each hold one item, so one item enters and leaves per
//   clock while the receiver keeps out_ch.ready high.
//   When the receiver stalls, each stage holds its item and empty stages
//   still fill, so in_ch.ready drops only once all three stages are full.
//   Synchronous reset empties the pipeline and sets the mode to add.
// ============================================================================
`default_nettype none

module rgb_blend_modes_core
  import rbm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rbm_in_if.sink                     in_ch,
  rbm_out_if.source                  out_ch,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              v1_r, v2_r, v3_r;
  logic              last1_r, last2_r, last3_r;
  logic              rdy1, rdy2, rdy3;
  logic              cfg_wr;
  stage_en_t         stage_en;

  // Configuration register: written on the APB access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && (cfg_paddr[CFG_ADDR_W-1] == REG_BLEND_MODE)) begin
      mode_nxt = cfg_pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ADD;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[CFG_ADDR_W-1] == REG_BLEND_MODE) ?
                      {{(CFG_DATA_W-MODE_W){1'b0}}, mode_r} : '0;

  // Pipeline flow control: a stage loads when it is empty or moves on.
  assign rdy3 = !v3_r || out_ch.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_comb begin
    stage_en.s1 = rdy1 && in_ch.valid;
    stage_en.s2 = rdy2 && v1_r;
    stage_en.s3 = rdy3 && v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // The last-pixel flag travels alongside the channel data.
  always_ff @(posedge clk) begin
    if (stage_en.s1) last1_r <= in_ch.last_pixel;
    if (stage_en.s2) last2_r <= last1_r;
    if (stage_en.s3) last3_r <= last2_r;
  end

  // One datapath per color channel.
  rbm_channel u_red (
    .clk      (clk),
    .stage_en (stage_en),
    .mode     (mode_r),
    .top_pix  (in_ch.top_red),
    .bot_pix  (in_ch.bottom_red),
    .result   (out_ch.out_red)
  );

  rbm_channel u_green (
    .clk      (clk),
    .stage_en (stage_en),
    .mode     (mode_r),
    .top_pix  (in_ch.top_green),
    .bot_pix  (in_ch.bottom_green),
    .result   (out_ch.out_green)
  );

  rbm_channel u_blue (
    .clk      (clk),
    .stage_en (stage_en),
    .mode     (mode_r),
    .top_pix  (in_ch.top_blue),
    .bot_pix  (in_ch.bottom_blue),
    .result   (out_ch.out_blue)
  );

  assign out_ch.valid    = v3_r;
  assign out_ch.out_last = last3_r;

  // Input is refused only when every stage is full and the output stalls.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && v2_r && v3_r && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

  // A blocked stage keeps its item.
  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> v1_r)
    else $error("stage 1 item lost while blocked");

  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(last2_r)))
    else $error("stage 2 item lost while blocked");

  // A mode write lands in the register.
  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (cfg_paddr[CFG_ADDR_W-1] == REG_BLEND_MODE))
      |=> (mode_r == $past(cfg_pwdata[MODE_W-1:0])))
    else $error("blend mode write not taken");

endmodule : rgb_blend_modes_core

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the RGB blend-mode core.
// ============================================================================
// Pixel pairs go in over the input channel in bursts, and blended pixels
// are checked against a predictor that rounds each quotient to nearest.
// The bench covers every blend mode, the unused mode codes, wide register
// values, writes to an unknown register and a long output stall. The sender
// idles at random and the receiver stalls at random.
// ============================================================================

module tb;
  import rbm_pkg::*;

  // Mode codes without an operation; they give a black pixel.
  localparam logic [MODE_W-1:0] MODE_RSVD_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;

  // Register index that holds nothing.
  localparam int UNUSED_REG_INDEX = 1;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [PIX_W-1:0] top_red;
    logic [PIX_W-1:0] top_green;
    logic [PIX_W-1:0] top_blue;
    logic [PIX_W-1:0] bottom_red;
    logic [PIX_W-1:0] bottom_green;
    logic [PIX_W-1:0] bottom_blue;
    logic             last_pixel;
  } pixel_pair_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
  } blended_px_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  rbm_in_if  in_ch ();
  rbm_out_if out_ch ();

  // Mode the block should hold, and the blended pixels still to come.
  logic [MODE_W-1:0] mode_now;
  blended_px_t       blended_q[$];

  int errors       = 0;
  int results_seen = 0;
  int cycle_count  = 0;
  int hold_cycles  = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b1;

  rgb_blend_modes_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Round x / 255 to nearest; ties cannot happen since 255 is odd.
  function automatic int div255_round(input int x);
    return (2 * x + 255) / 510;
  endfunction

  // Blend one channel pair under the given mode.
  function automatic logic [PIX_W-1:0] mix_channel(input logic [MODE_W-1:0] mode,
                                                   input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
    int ia;
    int ib;
    int full;
    int res;
    ia   = int'(a);
    ib   = int'(b);
    full = int'(PIX_MAX);
    case (mode)
      MODE_ADD: begin
        res = (ia + ib > full) ? full : ia + ib;
      end
      MODE_SUBTRACT: begin
        res = (ia > ib) ? ia - ib : 0;
      end
      MODE_MULTIPLY: begin
        res = div255_round(ia * ib);
      end
      MODE_SCREEN: begin
        res = full - div255_round((full - ia) * (full - ib));
      end
      MODE_OVERLAY: begin
        // Dark bottom channels multiply, light ones screen.
        if (ib <= 127) begin
          res = div255_round(2 * ia * ib);
        end else begin
          res = full - div255_round(2 * (full - ia) * (full - ib));
        end
      end
      default: begin
        res = 0;
      end
    endcase
    return res[PIX_W-1:0];
  endfunction

  function automatic blended_px_t blend_pixel(input pixel_pair_t p,
                                              input logic [MODE_W-1:0] mode);
    blended_px_t r;
    r.red   = mix_channel(mode, p.top_red, p.bottom_red);
    r.green = mix_channel(mode, p.top_green, p.bottom_green);
    r.blue  = mix_channel(mode, p.top_blue, p.bottom_blue);
    r.last  = p.last_pixel;
    return r;
  endfunction

  function automatic pixel_pair_t make_pair(input int tr, input int tg, input int tb_,
                                            input int br, input int bg, input int bb,
                                            input bit last);
    pixel_pair_t p;
    p.top_red      = tr[PIX_W-1:0];
    p.top_green    = tg[PIX_W-1:0];
    p.top_blue     = tb_[PIX_W-1:0];
    p.bottom_red   = br[PIX_W-1:0];
    p.bottom_green = bg[PIX_W-1:0];
    p.bottom_blue  = bb[PIX_W-1:0];
    p.last_pixel   = last;
    return p;
  endfunction

  // Mostly uniform values, with the clamp and overlay edges weighted up.
  function automatic int pick_channel();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return int'(PIX_MAX);
      2: return $urandom_range(127, 128);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic pixel_pair_t random_pair();
    return make_pair(pick_channel(), pick_channel(), pick_channel(),
                     pick_channel(), pick_channel(), pick_channel(),
                     $urandom_range(0, 7) == 0);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
    errors++;
  endtask

  // Two-phase register write; the shadow mode follows the block's decode.
  // The task waits with psel low before it returns, so writes never run into each other.
  task automatic cfg_write(input int idx, input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == int'(REG_BLEND_MODE)) begin
      mode_now = value[MODE_W-1:0];
    end
    @(posedge clk);
  endtask

  // Offer one item and hold it until accepted; gaps open between bursts.
  task automatic send_pixel(input pixel_pair_t p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.top_red      <= p.top_red;
    in_ch.top_green    <= p.top_green;
    in_ch.top_blue     <= p.top_blue;
    in_ch.bottom_red   <= p.bottom_red;
    in_ch.bottom_green <= p.bottom_green;
    in_ch.bottom_blue  <= p.bottom_blue;
    in_ch.last_pixel   <= p.last_pixel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every blended pixel has come back. The first
  // edge lets the prediction for the last accepted item reach the queue.
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (blended_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Corner pixels: clamps on add and subtract, full scale, overlay split.
  task automatic send_edge_set();
    send_pixel(make_pair(0, 255, 0, 0, 0, 255, 1'b0));
    send_pixel(make_pair(255, 128, 127, 255, 127, 128, 1'b1));
    send_pixel(make_pair(127, 1, 254, 128, 254, 1, 1'b0));
  endtask

  task automatic test_reset_mode();
    // No write yet: the block must blend with add.
    send_edge_set();
    drain_pipeline();
  endtask

  task automatic test_each_mode();
    cfg_write(int'(REG_BLEND_MODE), CFG_DATA_W'(MODE_SUBTRACT));
    send_edge_set();
    drain_pipeline();
    cfg_write(int'(REG_BLEND_MODE), CFG_DATA_W'(MODE_MULTIPLY));
    send_edge_set();
    drain_pipeline();
    cfg_write(int'(REG_BLEND_MODE), CFG_DATA_W'(MODE_SCREEN));
    send_edge_set();
    drain_pipeline();
    cfg_write(int'(REG_BLEND_MODE), CFG_DATA_W'(MODE_OVERLAY));
    send_edge_set();
    drain_pipeline();
  endtask

  task automatic test_unused_modes();
    // Upper bits of the written value must be dropped.
    cfg_write(int'(REG_BLEND_MODE), {{(CFG_DATA_W-MODE_W){1'b1}}, MODE_RSVD_5});
    send_edge_set();
    drain_pipeline();
    cfg_write(int'(REG_BLEND_MODE), CFG_DATA_W'(MODE_RSVD_6));
    send_edge_set();
    drain_pipeline();
    cfg_write(int'(REG_BLEND_MODE), {1'b1, {(CFG_DATA_W-MODE_W-1){1'b0}}, MODE_RSVD_7});
    send_edge_set();
    drain_pipeline();
  endtask

  task automatic test_unknown_register();
    // The second write goes nowhere, so multiply must stay in force.
    cfg_write(int'(REG_BLEND_MODE), CFG_DATA_W'(MODE_MULTIPLY));
    cfg_write(UNUSED_REG_INDEX, CFG_DATA_W'(MODE_SCREEN));
    send_pixel(make_pair(200, 100, 50, 30, 160, 255, 1'b1));
    send_pixel(make_pair(255, 255, 255, 255, 255, 255, 1'b0));
    drain_pipeline();
  endtask

  task automatic test_full_pipeline();
    int k;
    // The receiver holds off while items keep coming, so the input stalls.
    cfg_write(int'(REG_BLEND_MODE), CFG_DATA_W'(MODE_OVERLAY));
    gaps_on     = 1'b0;
    hold_cycles = 120;
    for (k = 0; k < 60; k++) begin
      send_pixel(random_pair());
    end
    drain_pipeline();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int sent;
    int phase;
    int len;
    int k;
    logic [MODE_W-1:0] mode;
    logic [CFG_DATA_W-1:0] value;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      // Walk the codes in order from 0, then pick codes at random.
      mode  = (phase < 8) ? MODE_W'(phase) : MODE_W'($urandom_range(0, 7));
      value = CFG_DATA_W'(mode);
      if ($urandom_range(0, 1) == 1) begin
        value = ($urandom() & ~CFG_DATA_W'(7)) | CFG_DATA_W'(mode);
      end
      cfg_write(int'(REG_BLEND_MODE), value);
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(UNUSED_REG_INDEX, $urandom());
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      len     = $urandom_range(120, 260);
      for (k = 0; k < len; k++) begin
        send_pixel(random_pair());
      end
      sent += len;
      phase++;
      drain_pipeline();
    end
  endtask

  // Receiver: stall rate changes from window to window; a requested
  // hold-off overrides it.
  initial begin : receiver
    int pct;
    int window;
    pct          = 0;
    window       = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (window == 0) begin
        window = $urandom_range(50, 300);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          default: pct = 85;
        endcase
      end
      window--;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(1, 100) > pct);
      end
    end
  end

  // Predict the blended pixel for every accepted item.
  always @(posedge clk) begin : predict_results
    pixel_pair_t seen;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.top_red      = in_ch.top_red;
      seen.top_green    = in_ch.top_green;
      seen.top_blue     = in_ch.top_blue;
      seen.bottom_red   = in_ch.bottom_red;
      seen.bottom_green = in_ch.bottom_green;
      seen.bottom_blue  = in_ch.bottom_blue;
      seen.last_pixel   = in_ch.last_pixel;
      blended_q.insert(blended_q.size(), blend_pixel(seen, mode_now));
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    blended_px_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (blended_q.size() == 0) begin
        report_mismatch("result with nothing pending, red", int'(out_ch.out_red), 0);
      end else begin
        want = blended_q.pop_front();
        if (out_ch.out_red !== want.red) begin
          report_mismatch("out_red", int'(out_ch.out_red), int'(want.red));
        end
        if (out_ch.out_green !== want.green) begin
          report_mismatch("out_green", int'(out_ch.out_green), int'(want.green));
        end
        if (out_ch.out_blue !== want.blue) begin
          report_mismatch("out_blue", int'(out_ch.out_blue), int'(want.blue));
        end
        if (out_ch.out_last !== want.last) begin
          report_mismatch("out_last", int'(out_ch.out_last), int'(want.last));
        end
      end
      results_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    mode_now           = MODE_ADD;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    in_ch.valid        = 1'b0;
    in_ch.top_red      = '0;
    in_ch.top_green    = '0;
    in_ch.top_blue     = '0;
    in_ch.bottom_red   = '0;
    in_ch.bottom_green = '0;
    in_ch.bottom_blue  = '0;
    in_ch.last_pixel   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_mode();
    test_each_mode();
    test_unused_modes();
    test_unknown_register();
    test_full_pipeline();
    test_random_stream();
    drain_pipeline();

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule : tb

@@ rgb_blend_modes_core.f @@
rtl/core/rbm_pkg.sv
rtl/core/rbm_if.sv
rtl/core/rbm_channel.sv
rtl/core/rgb_blend_modes_core.sv
tb/sv/tb.sv
